// ----- design/pedal_force_kalman_scaler_assert.svh -----
// Assertion macros shared by the pedal force scaler.
`ifndef PEDAL_FORCE_KALMAN_SCALER_ASSERT_SVH
`define PEDAL_FORCE_KALMAN_SCALER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PFKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pfks_pkg.sv -----
// Package with the microcode table, control word type and constants of the pedal force scaler.
`timescale 1ns / 1ps
`default_nettype none

package pfks_pkg;

    localparam int STEP_W = 5;
    localparam int OP_W   = 4;
    localparam int COND_W = 3;

    // Datapath operations.
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_MUL_SCALE = 4'd1;
    localparam logic [OP_W-1:0] OP_LD_VOLT   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd3;
    localparam logic [OP_W-1:0] OP_SAVE_VOLT = 4'd4;
    localparam logic [OP_W-1:0] OP_LD_GAIN   = 4'd5;
    localparam logic [OP_W-1:0] OP_SAVE_GAIN = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_MOVE  = 4'd7;
    localparam logic [OP_W-1:0] OP_UPD_EST   = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_ERR1  = 4'd9;
    localparam logic [OP_W-1:0] OP_MUL_ERR2  = 4'd10;
    localparam logic [OP_W-1:0] OP_UPD_ERR   = 4'd11;
    localparam logic [OP_W-1:0] OP_MUL_LVL   = 4'd12;
    localparam logic [OP_W-1:0] OP_LD_LVL    = 4'd13;
    localparam logic [OP_W-1:0] OP_SAVE_LVL  = 4'd14;
    localparam logic [OP_W-1:0] OP_FINISH    = 4'd15;

    // Sequencer conditions.
    localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
    localparam logic [COND_W-1:0] C_WAIT_IN  = 3'd1;
    localparam logic [COND_W-1:0] C_LOOP     = 3'd2;
    localparam logic [COND_W-1:0] C_SKIP     = 3'd3;
    localparam logic [COND_W-1:0] C_WAIT_OUT = 3'd4;
    localparam logic [COND_W-1:0] C_JUMP     = 3'd5;

    // Program steps.
    localparam logic [STEP_W-1:0] STEP_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_SCALE = 5'd1;
    localparam logic [STEP_W-1:0] STEP_LD_VOLT   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_SAVE_VOLT = 5'd3;
    localparam logic [STEP_W-1:0] STEP_LD_GAIN   = 5'd4;
    localparam logic [STEP_W-1:0] STEP_DIV_GAIN  = 5'd5;
    localparam logic [STEP_W-1:0] STEP_SAVE_GAIN = 5'd6;
    localparam logic [STEP_W-1:0] STEP_MUL_MOVE  = 5'd7;
    localparam logic [STEP_W-1:0] STEP_UPD_EST   = 5'd8;
    localparam logic [STEP_W-1:0] STEP_MUL_ERR1  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_MUL_ERR2  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_UPD_ERR   = 5'd11;
    localparam logic [STEP_W-1:0] STEP_MUL_LVL   = 5'd12;
    localparam logic [STEP_W-1:0] STEP_LD_LVL    = 5'd13;
    localparam logic [STEP_W-1:0] STEP_SAVE_LVL  = 5'd14;
    localparam logic [STEP_W-1:0] STEP_FINISH    = 5'd15;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_VOLTAGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_ERR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_ERR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS      = 3'd4;

    // Register reset values.
    localparam logic [15:0] FULL_SCALE_RST = 16'd13517;
    localparam logic [15:0] REST_RST       = 16'd0;
    localparam logic [31:0] MEASURE_RST    = 32'd65536;
    localparam logic [31:0] INIT_ERR_RST   = 32'd65536;
    localparam logic [15:0] PROCESS_RST    = 16'd655;

    // Top ADC code; the scaled sample is divided by it with a fold on 4096.
    localparam logic [12:0] ADC_MAX_CODE = 13'd4095;
    // 6553500/675840 reduces to 109225/11264, and 11264 is 1024 times 11.
    localparam logic [16:0] SPAN_NUM     = 17'd109225;
    // 2^24/11 rounded up; exact for dividends below 2^20.
    localparam logic [20:0] LVL_RECIP    = 21'd1525202;
    // Scaled span at which the level reaches 65536 and saturates.
    localparam logic [32:0] SPAN_SAT     = 33'd738197504;
    localparam logic [16:0] GAIN_ONE     = 17'h10000;

    localparam logic [4:0] DIV_LEN_17 = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_JUMP, target: STEP_IDLE};
        case (step)
            STEP_IDLE:      w = '{op: OP_NOP,       cond: C_WAIT_IN,  target: STEP_IDLE};
            STEP_MUL_SCALE: w = '{op: OP_MUL_SCALE, cond: C_NEXT,     target: STEP_IDLE};
            STEP_LD_VOLT:   w = '{op: OP_LD_VOLT,   cond: C_NEXT,     target: STEP_IDLE};
            STEP_SAVE_VOLT: w = '{op: OP_SAVE_VOLT, cond: C_NEXT,     target: STEP_IDLE};
            STEP_LD_GAIN:   w = '{op: OP_LD_GAIN,   cond: C_SKIP,     target: STEP_MUL_MOVE};
            STEP_DIV_GAIN:  w = '{op: OP_DIV_STEP,  cond: C_LOOP,     target: STEP_DIV_GAIN};
            STEP_SAVE_GAIN: w = '{op: OP_SAVE_GAIN, cond: C_NEXT,     target: STEP_IDLE};
            STEP_MUL_MOVE:  w = '{op: OP_MUL_MOVE,  cond: C_NEXT,     target: STEP_IDLE};
            STEP_UPD_EST:   w = '{op: OP_UPD_EST,   cond: C_NEXT,     target: STEP_IDLE};
            STEP_MUL_ERR1:  w = '{op: OP_MUL_ERR1,  cond: C_NEXT,     target: STEP_IDLE};
            STEP_MUL_ERR2:  w = '{op: OP_MUL_ERR2,  cond: C_NEXT,     target: STEP_IDLE};
            STEP_UPD_ERR:   w = '{op: OP_UPD_ERR,   cond: C_NEXT,     target: STEP_IDLE};
            STEP_MUL_LVL:   w = '{op: OP_MUL_LVL,   cond: C_NEXT,     target: STEP_IDLE};
            STEP_LD_LVL:    w = '{op: OP_LD_LVL,    cond: C_SKIP,     target: STEP_FINISH};
            STEP_SAVE_LVL:  w = '{op: OP_SAVE_LVL,  cond: C_NEXT,     target: STEP_IDLE};
            STEP_FINISH:    w = '{op: OP_FINISH,    cond: C_WAIT_OUT, target: STEP_IDLE};
            default:        w = '{op: OP_NOP,       cond: C_JUMP,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/pedal_force_kalman_scaler.sv -----
// Pedal force scaler: ADC scaling, scalar Kalman step and brake level, run by a microcode sequencer.
// A word is accepted only in the idle step, so it waits until the last word's program has ended;
// a level at rest or saturated skips the level save, a zero gain denominator the gain division.
// The program runs on the shared one-bit-a-cycle gain divider (17 steps) and the shared multiplier.
// A stalled result holds the next word's program in its last step until the result is taken.
// Reset clears the sequencer, the result valid, the estimate, and loads the registers' reset values.
`timescale 1ns / 1ps
`default_nettype none

`include "pedal_force_kalman_scaler_assert.svh"

module pedal_force_kalman_scaler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    output logic             sample_stall,
    input  wire logic [11:0] sample,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      brake_level,
    output logic [15:0]      filtered_voltage,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Configuration registers.
    logic [15:0] full_scale_reg;
    logic [15:0] rest_reg;
    logic [31:0] measure_reg;
    logic [31:0] init_err_reg;
    logic [15:0] process_reg;

    // Filter state.
    logic [15:0] est_reg;
    logic [31:0] err_reg;

    // Sequencer.
    logic [pfks_pkg::STEP_W-1:0] pc_reg;
    logic [pfks_pkg::STEP_W-1:0] pc_next;
    pfks_pkg::ucode_t            uw;

    // Datapath.
    logic [11:0] sample_reg;
    logic [15:0] volts_reg;
    logic [16:0] gain_reg;
    logic        dir_reg;
    logic [15:0] delta_reg;
    logic [31:0] acc_reg;
    logic [15:0] level_reg;
    logic [48:0] prod_reg;

    // Restoring divider.
    logic [32:0] rem_reg;
    logic [16:0] quo_reg;
    logic [32:0] dsr_reg;
    logic [4:0]  cnt_reg;

    // Output register.
    logic        result_valid_reg;
    logic [15:0] brake_out_reg;
    logic [15:0] volt_out_reg;

    logic        in_fire;
    logic        out_free;
    logic        skip;
    logic [19:0] mul_a;
    logic [31:0] mul_b;
    logic [51:0] mul_prod;
    logic        mul_en;
    logic [15:0] mag;
    logic        dir_now;
    logic [32:0] den;
    logic [32:0] ne_sum;
    logic [15:0] lvl_diff;
    logic        lvl_low;
    logic        lvl_sat;
    logic [33:0] rem_sh;
    logic [33:0] rem_sub;
    logic        rem_ge;
    logic [15:0] move;
    logic [16:0] fold_sum;
    logic [12:0] fold_rest;
    logic        fold_carry;

    assign uw           = pfks_pkg::ucode_word(pc_reg);
    assign sample_stall = (pc_reg != pfks_pkg::STEP_IDLE);
    assign in_fire      = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign cfg_ready    = 1'b1;

    assign result_valid     = result_valid_reg;
    assign brake_level      = brake_out_reg;
    assign filtered_voltage = volt_out_reg;

    assign dir_now  = (volts_reg >= est_reg);
    assign mag      = dir_now ? (volts_reg - est_reg) : (est_reg - volts_reg);
    assign den      = {1'b0, err_reg} + {1'b0, measure_reg};
    assign ne_sum   = {1'b0, acc_reg} + {13'd0, prod_reg[31:12]};
    assign lvl_diff = est_reg - rest_reg;
    assign lvl_low  = (est_reg <= rest_reg);
    assign lvl_sat  = (prod_reg[32:0] >= pfks_pkg::SPAN_SAT);
    assign move     = prod_reg[31:16];

    assign rem_sh  = {rem_reg, quo_reg[16]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign rem_ge  = (rem_sh >= {1'b0, dsr_reg});

    // Division by 4095: x = 4095*q0 + (q0 + low) with q0 = x >> 12, folded twice.
    assign fold_sum   = {1'b0, prod_reg[27:12]} + {5'd0, prod_reg[11:0]};
    assign fold_rest  = {1'b0, rem_reg[11:0]} + {8'd0, rem_reg[16:12]};
    assign fold_carry = (fold_rest >= pfks_pkg::ADC_MAX_CODE);

    always_comb
    begin
        case (uw.op)
            pfks_pkg::OP_LD_GAIN: skip = (den == '0);
            pfks_pkg::OP_LD_LVL:  skip = lvl_low || lvl_sat;
            default:              skip = 1'b0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (uw.op)
            pfks_pkg::OP_MUL_SCALE:
            begin
                mul_a = {8'd0, sample_reg};
                mul_b = {16'd0, full_scale_reg};
            end
            pfks_pkg::OP_MUL_MOVE:
            begin
                mul_a = {3'd0, gain_reg};
                mul_b = {16'd0, mag};
            end
            pfks_pkg::OP_MUL_ERR1:
            begin
                mul_a = {3'd0, (pfks_pkg::GAIN_ONE - gain_reg)};
                mul_b = err_reg;
            end
            pfks_pkg::OP_MUL_ERR2:
            begin
                mul_a = {4'd0, delta_reg};
                mul_b = {16'd0, process_reg};
            end
            pfks_pkg::OP_MUL_LVL:
            begin
                mul_a = {3'd0, pfks_pkg::SPAN_NUM};
                mul_b = {16'd0, lvl_diff};
            end
            pfks_pkg::OP_LD_LVL:
            begin
                // Below saturation the span product over 1024 fits 20 bits.
                mul_a = prod_reg[29:10];
                mul_b = {11'd0, pfks_pkg::LVL_RECIP};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mul_prod = 52'(mul_a) * 52'(mul_b);

    always_comb
    begin
        case (uw.cond)
            pfks_pkg::C_NEXT:     pc_next = pc_reg + 1'b1;
            pfks_pkg::C_WAIT_IN:  pc_next = in_fire ? pc_reg + 1'b1 : pc_reg;
            pfks_pkg::C_LOOP:     pc_next = (cnt_reg != 5'd1) ? uw.target : pc_reg + 1'b1;
            pfks_pkg::C_SKIP:     pc_next = skip ? uw.target : pc_reg + 1'b1;
            pfks_pkg::C_WAIT_OUT: pc_next = out_free ? uw.target : pc_reg;
            pfks_pkg::C_JUMP:     pc_next = uw.target;
            default:              pc_next = pfks_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= pfks_pkg::STEP_IDLE;
            result_valid_reg <= 1'b0;
            full_scale_reg   <= pfks_pkg::FULL_SCALE_RST;
            rest_reg         <= pfks_pkg::REST_RST;
            measure_reg      <= pfks_pkg::MEASURE_RST;
            init_err_reg     <= pfks_pkg::INIT_ERR_RST;
            process_reg      <= pfks_pkg::PROCESS_RST;
            est_reg          <= '0;
            err_reg          <= pfks_pkg::INIT_ERR_RST;
        end
        else
        begin
            pc_reg <= pc_next;

            if (uw.op == pfks_pkg::OP_FINISH && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (uw.op == pfks_pkg::OP_UPD_EST)
            begin
                est_reg <= dir_reg ? (est_reg + move) : (est_reg - move);
            end

            // Configure only while idle, clear of the error update; the block does not enforce it.
            if (uw.op == pfks_pkg::OP_UPD_ERR)
            begin
                err_reg <= ne_sum[32] ? 32'hFFFF_FFFF : ne_sum[31:0];
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pfks_pkg::REG_FULL_SCALE:   full_scale_reg <= cfg_data[15:0];
                    pfks_pkg::REG_REST_VOLTAGE: rest_reg       <= cfg_data[15:0];
                    pfks_pkg::REG_MEASURE_ERR:  measure_reg    <= cfg_data;
                    pfks_pkg::REG_INIT_ERR:
                    begin
                        init_err_reg <= cfg_data;
                        err_reg      <= cfg_data;
                    end
                    pfks_pkg::REG_PROCESS:      process_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers; these carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= sample;
        end

        if (mul_en)
        begin
            prod_reg <= mul_prod[48:0];
        end

        case (uw.op)
            pfks_pkg::OP_LD_VOLT:
            begin
                quo_reg <= {1'b0, prod_reg[27:12]};
                rem_reg <= {16'd0, fold_sum};
            end
            pfks_pkg::OP_LD_GAIN:
            begin
                // The dividend is the error shifted up by 16; its top part seeds the remainder.
                rem_reg  <= {2'd0, err_reg[31:1]};
                quo_reg  <= {err_reg[0], 16'd0};
                dsr_reg  <= den;
                cnt_reg  <= pfks_pkg::DIV_LEN_17;
                gain_reg <= '0;
            end
            pfks_pkg::OP_LD_LVL:
            begin
                level_reg <= lvl_low ? 16'd0 : 16'hFFFF;
            end
            pfks_pkg::OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? rem_sub[32:0] : rem_sh[32:0];
                quo_reg <= {quo_reg[15:0], rem_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            pfks_pkg::OP_SAVE_VOLT:
                volts_reg <= quo_reg[15:0] + {11'd0, rem_reg[16:12]} + {15'd0, fold_carry};
            pfks_pkg::OP_SAVE_GAIN: gain_reg  <= quo_reg;
            pfks_pkg::OP_MUL_MOVE:  dir_reg   <= dir_now;
            pfks_pkg::OP_UPD_EST:   delta_reg <= move;
            pfks_pkg::OP_MUL_ERR2:  acc_reg   <= prod_reg[47:16];
            pfks_pkg::OP_SAVE_LVL:  level_reg <= prod_reg[39:24];
            pfks_pkg::OP_FINISH:
            begin
                if (out_free)
                begin
                    brake_out_reg <= level_reg;
                    volt_out_reg  <= est_reg;
                end
            end
            default: ;
        endcase
    end

    `PFKS_ASSERT_NEXT(a_accept_starts_program, clk, rst_n,
        sample_valid && !sample_stall, pc_reg == pfks_pkg::STEP_MUL_SCALE,
        "accepted word did not start the program")

    `PFKS_ASSERT_NOW(a_result_from_finish, clk, rst_n,
        $rose(result_valid_reg), $past(pc_reg) == pfks_pkg::STEP_FINISH,
        "result raised outside the finish step")

    `PFKS_ASSERT_NOW(a_gain_bounded, clk, rst_n,
        pc_reg == pfks_pkg::STEP_MUL_MOVE, gain_reg <= pfks_pkg::GAIN_ONE,
        "Kalman gain above one")

    `PFKS_ASSERT_NOW(a_div_count_live, clk, rst_n,
        uw.op == pfks_pkg::OP_DIV_STEP, cnt_reg != 5'd0,
        "divider stepping with an empty count")

endmodule

`default_nettype wire
